[sv/wsd_pkg.sv]
package wsd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned LEN_W    = 64;
   localparam int unsigned KEY_W    = 32;
   localparam int unsigned EXT_W    = 4;

   // frame_status codes
   localparam logic [STATUS_W-1:0] STATUS_TEXT  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CLOSE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

   // opcodes accepted in the first header byte
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;

   // 7-bit length field codes
   localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
   localparam logic [6:0] LEN_EXT16     = 7'd126;

   localparam logic [EXT_W-1:0] EXT16_BYTES = 4'd2;
   localparam logic [EXT_W-1:0] EXT64_BYTES = 4'd8;

endpackage

[sv/wsd_req_if.sv]
interface wsd_req_if;
   logic                          valid;
   logic                          ready;
   logic [wsd_pkg::BYTE_W-1:0]    in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

[sv/wsd_rsp_if.sv]
interface wsd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wsd_pkg::BYTE_W-1:0]    out_byte;
   logic                          byte_valid;
   logic                          frame_end;
   logic [wsd_pkg::STATUS_W-1:0]  frame_status;

   modport source (output valid, output out_byte, output byte_valid,
                   output frame_end, output frame_status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input frame_end, input frame_status, output ready);
endinterface

[sv/websocket_frame_deframer.sv]
// Channel   Direction  Beat contents
// --------  ---------  ---------------------------------------------------
// req_bus   in         in_byte: one received stream byte
// rsp_bus   out        out_byte, byte_valid, frame_end, frame_status
// csr_*     in         require_mask (write only)
//
// One byte per cycle sustained while rsp_bus does not stall: an input register
// feeds the header/unmask logic, whose result beat, if any, lands in an output register.
// Synchronous active-high reset returns the parser to the first header byte
// and sets require_mask. A stalled rsp_bus holds the input stage once it is
// full; header and key bytes still need the output slot free to move on.
module websocket_frame_deframer (
   input  logic                clock,
   input  logic                reset,
   wsd_req_if.sink             req_bus,
   wsd_rsp_if.source           rsp_bus,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_KEY,
      PH_DATA,
      PH_DEAD
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic                               close_ff, close_in;
   logic [wsd_pkg::EXT_W-1:0]          ext_left_ff, ext_left_in;
   logic [wsd_pkg::LEN_W-1:0]          payload_left_ff, payload_left_in;
   logic [wsd_pkg::KEY_W-1:0]          mask_key_ff, mask_key_in;
   logic [1:0]                         key_index_ff, key_index_in;
   logic                               require_mask_ff;

   logic                               in_valid_ff;
   logic [wsd_pkg::BYTE_W-1:0]         in_byte_ff;

   logic                               out_valid_ff, out_valid_in;
   logic [wsd_pkg::BYTE_W-1:0]         out_byte_ff;
   logic                               byte_valid_ff;
   logic                               frame_end_ff;
   logic [wsd_pkg::STATUS_W-1:0]       frame_status_ff;

   logic                               advance;
   logic                               res_valid;
   logic [wsd_pkg::BYTE_W-1:0]         res_byte;
   logic                               res_byte_valid;
   logic                               res_end;
   logic [wsd_pkg::STATUS_W-1:0]       res_status;
   logic [wsd_pkg::STATUS_W-1:0]       done_status;
   logic [3:0]                         opcode;
   logic [6:0]                         len7;
   logic [wsd_pkg::BYTE_W-1:0]         key_byte;

   // the stage moves whenever the output slot is free or being drained
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   assign opcode      = in_byte_ff[3:0];
   assign len7        = in_byte_ff[6:0];
   assign key_byte    = mask_key_ff[{~key_index_ff, 3'b000} +: wsd_pkg::BYTE_W];
   assign done_status = close_ff ? wsd_pkg::STATUS_CLOSE : wsd_pkg::STATUS_TEXT;

   always_comb begin
      phase_in        = phase_ff;
      close_in        = close_ff;
      ext_left_in     = ext_left_ff;
      payload_left_in = payload_left_ff;
      mask_key_in     = mask_key_ff;
      key_index_in    = key_index_ff;
      res_valid       = 1'b0;
      res_byte        = '0;
      res_byte_valid  = 1'b0;
      res_end         = 1'b0;
      res_status      = wsd_pkg::STATUS_TEXT;
      if (advance) begin
         unique case (phase_ff)
            PH_HDR0: begin
               if (!in_byte_ff[7] || (in_byte_ff[6:4] != 3'b000) ||
                   ((opcode != wsd_pkg::OP_TEXT) && (opcode != wsd_pkg::OP_CLOSE))) begin
                  phase_in   = PH_DEAD;
                  res_valid  = 1'b1;
                  res_end    = 1'b1;
                  res_status = wsd_pkg::STATUS_ERROR;
               end else begin
                  close_in = (opcode == wsd_pkg::OP_CLOSE);
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               if (require_mask_ff && !in_byte_ff[7]) begin
                  phase_in   = PH_DEAD;
                  res_valid  = 1'b1;
                  res_end    = 1'b1;
                  res_status = wsd_pkg::STATUS_ERROR;
               end else begin
                  mask_key_in  = '0;
                  key_index_in = '0;
                  if (len7 <= wsd_pkg::LEN_SHORT_MAX) begin
                     payload_left_in = {{(wsd_pkg::LEN_W-7){1'b0}}, len7};
                     phase_in        = PH_KEY;
                  end else begin
                     payload_left_in = '0;
                     ext_left_in     = (len7 == wsd_pkg::LEN_EXT16) ?
                                       wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
                     phase_in        = PH_EXT;
                  end
               end
            end
            PH_EXT: begin
               payload_left_in = {payload_left_ff[wsd_pkg::LEN_W-9:0], in_byte_ff};
               ext_left_in     = ext_left_ff - 4'd1;
               if (ext_left_ff == 4'd1) begin
                  // top bit of the assembled length comes from bit 55 before the shift
                  if (payload_left_ff[wsd_pkg::LEN_W-9]) begin
                     phase_in   = PH_DEAD;
                     res_valid  = 1'b1;
                     res_end    = 1'b1;
                     res_status = wsd_pkg::STATUS_ERROR;
                  end else begin
                     phase_in = PH_KEY;
                  end
               end
            end
            PH_KEY: begin
               mask_key_in  = {mask_key_ff[wsd_pkg::KEY_W-9:0], in_byte_ff};
               key_index_in = key_index_ff + 2'd1;
               if (key_index_ff == 2'd3) begin
                  if (payload_left_ff == '0) begin
                     phase_in   = PH_HDR0;
                     res_valid  = 1'b1;
                     res_end    = 1'b1;
                     res_status = done_status;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               key_index_in    = key_index_ff + 2'd1;
               payload_left_in = payload_left_ff - 64'd1;
               res_valid       = 1'b1;
               res_byte        = in_byte_ff ^ key_byte;
               res_byte_valid  = 1'b1;
               if (payload_left_ff == 64'd1) begin
                  phase_in   = PH_HDR0;
                  res_end    = 1'b1;
                  res_status = done_status;
               end
            end
            default: begin
               phase_in = PH_DEAD;
            end
         endcase
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = res_valid;
      end else begin
         out_valid_in = out_valid_ff && !rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         close_ff        <= 1'b0;
         ext_left_ff     <= '0;
         payload_left_ff <= '0;
         mask_key_ff     <= '0;
         key_index_ff    <= '0;
         require_mask_ff <= 1'b1;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         close_ff        <= close_in;
         ext_left_ff     <= ext_left_in;
         payload_left_ff <= payload_left_in;
         mask_key_ff     <= mask_key_in;
         key_index_ff    <= key_index_in;
         if (csr_wr_en) begin
            require_mask_ff <= csr_wr_data;
         end
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.in_byte;
      end
      if (advance && res_valid) begin
         out_byte_ff     <= res_byte;
         byte_valid_ff   <= res_byte_valid;
         frame_end_ff    <= res_end;
         frame_status_ff <= res_status;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.out_byte     = out_byte_ff;
   assign rsp_bus.byte_valid   = byte_valid_ff;
   assign rsp_bus.frame_end    = frame_end_ff;
   assign rsp_bus.frame_status = frame_status_ff;

endmodule
